/* sv/md5c_pkg.sv */
package md5c_pkg;

   localparam int WordWidth = 32;
   localparam int NumWords = 16;
   localparam int NumRounds = 64;

   localparam logic [WordWidth-1:0] IvA = 32'h67452301;
   localparam logic [WordWidth-1:0] IvB = 32'hefcdab89;
   localparam logic [WordWidth-1:0] IvC = 32'h98badcfe;
   localparam logic [WordWidth-1:0] IvD = 32'h10325476;

   // tuser codes on the request channel
   localparam logic CmdWord = 1'b0;
   localparam logic CmdRestart = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL
   } md5c_state_type;

   function automatic logic [31:0] md5c_sine(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0: k = 32'hd76aa478;   6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;   6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;   6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;   6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;   6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // index is {round group, round mod 4}
   function automatic logic [4:0] md5c_shift(input logic [3:0] idx);
      logic [4:0] s;
      case (idx)
         4'd0: s = 5'd7;    4'd1: s = 5'd12;   4'd2: s = 5'd17;   4'd3: s = 5'd22;
         4'd4: s = 5'd5;    4'd5: s = 5'd9;    4'd6: s = 5'd14;   4'd7: s = 5'd20;
         4'd8: s = 5'd4;    4'd9: s = 5'd11;   4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // message word index for a round; the round group picks the formula, worked mod 16 on the low four bits
   function automatic logic [3:0] md5c_word_index(input logic [5:0] rnd);
      logic [3:0] r;
      logic [3:0] g;
      r = rnd[3:0];
      case (rnd[5:4])
         2'd0: g = r;
         2'd1: g = 4'(r * 4'd5 + 4'd1);
         2'd2: g = 4'(r * 4'd3 + 4'd5);
         default: g = 4'(r * 4'd7);
      endcase
      return g;
   endfunction

   function automatic logic [31:0] md5c_mix(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (grp)
         2'd0: f = (b & c) | (~b & d);
         2'd1: f = (d & b) | (~d & c);
         2'd2: f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

endpackage

/* sv/md5_block_compression_top.sv */
// Words 1..15 of a block and restart commands are taken in the idle state.
// The 16th word starts the 64 rounds on one shared round unit, then a final step folds
// the working words into the chaining value and registers the digest.
// Requests are not accepted while the round loop runs, so the round loop sets the rate.
// Synchronous active-high reset loads the MD5 initial value and clears the word count.
module md5_block_compression_top
   import md5c_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [31:0] message_word
   input  logic          req_tuser,   // [0] command
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata    // [31:0] digest_a, [63:32] digest_b,
                                      // [95:64] digest_c, [127:96] digest_d
);

   md5c_state_type state_ff, state_in;
   logic [3:0]     word_count_ff, word_count_in;
   logic [5:0]     round_ff, round_in;
   logic [31:0]    chain_ff [4];
   logic [31:0]    chain_in [4];
   logic [31:0]    work_ff [4];
   logic [31:0]    work_in [4];
   logic [31:0]    block_words_ff [NumWords];
   logic           rsp_valid_ff, rsp_valid_in;
   logic [127:0]   rsp_data_ff, rsp_data_in;

   logic           req_xfer;
   logic           word_we;
   logic [31:0]    mix;
   logic [31:0]    msg;
   logic [31:0]    sum;
   logic [63:0]    rot_wide;
   logic [31:0]    new_b;

   // round unit
   always_comb begin
      mix = md5c_mix(round_ff[5:4], work_ff[1], work_ff[2], work_ff[3]);
      msg = block_words_ff[md5c_word_index(round_ff)];
      sum = mix + work_ff[0] + md5c_sine(round_ff) + msg;
      rot_wide = {sum, sum} << md5c_shift({round_ff[5:4], round_ff[1:0]});
      new_b = work_ff[1] + rot_wide[63:32];
   end

   assign req_xfer = req_tvalid && req_tready;
   assign word_we = req_xfer && (req_tuser == CmdWord);

   always_comb begin
      state_in = state_ff;
      word_count_in = word_count_ff;
      round_in = round_ff;
      chain_in = chain_ff;
      work_in = work_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      // hold off the last word of a block while the previous digest still waits
      req_tready = (state_ff == ST_IDLE) && !(rsp_valid_ff && (word_count_ff == 4'd15));

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == CmdRestart) begin
                  chain_in[0] = IvA;
                  chain_in[1] = IvB;
                  chain_in[2] = IvC;
                  chain_in[3] = IvD;
                  word_count_in = 4'd0;
               end else begin
                  word_count_in = word_count_ff + 4'd1;
                  if (word_count_ff == 4'd15) begin
                     work_in = chain_ff;
                     round_in = 6'd0;
                     state_in = ST_ROUND;
                  end
               end
            end
         end
         ST_ROUND: begin
            work_in[0] = work_ff[3];
            work_in[1] = new_b;
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(NumRounds - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < 4; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            rsp_data_in = {chain_in[3], chain_in[2], chain_in[1], chain_in[0]};
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         word_count_ff <= 4'd0;
         round_ff <= 6'd0;
         rsp_valid_ff <= 1'b0;
         chain_ff[0] <= IvA;
         chain_ff[1] <= IvB;
         chain_ff[2] <= IvC;
         chain_ff[3] <= IvD;
      end else begin
         state_ff <= state_in;
         word_count_ff <= word_count_in;
         round_ff <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rsp_data_ff <= rsp_data_in;
      if (word_we) begin
         block_words_ff[word_count_ff] <= req_tdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_FINAL))
      else $error("digest raised outside the final step");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'(NumRounds - 1)) |=> state_ff == ST_FINAL)
      else $error("round loop did not end after the last round");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser == CmdWord && word_count_ff == 4'd15)
      |=> (state_ff == ST_ROUND && round_ff == 6'd0 && word_count_ff == 4'd0))
      else $error("block did not start at round zero");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |-> !rsp_valid_ff)
      else $error("digest overwritten before transfer");

endmodule
